// ===== sv/qvic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qvic_pkg: shared types and constants of the quad vertex index compactor
// Table geometry, field widths, register map and the structs that travel
// between the sequencer, the ID table memory and the top level.
// ---------------------------------------------------------------------------
package qvic_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ID_W        = 16;
	localparam int LOCAL_W     = 9;
	localparam int ADDED_W     = 3;
	localparam int TOTAL_W     = 10;
	localparam int CORNERS     = 4;

	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Register indexes of the configuration port.
	localparam int REG_RESERVED_ID = 0;

	localparam logic [ID_W-1:0] RESERVED_ID_RESET = 16'hFFFF;

	typedef logic [CORNERS-1:0][ID_W-1:0] qvic_ids_t;

	// Write and read request towards the ID table memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ID_W-1:0]  wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} qvic_ram_req_t;

	// One finished result beat.
	typedef struct packed {
		logic [CORNERS-1:0][LOCAL_W-1:0] locals;
		logic [ADDED_W-1:0]              added_count;
		qvic_ids_t                       added;
		logic [TOTAL_W-1:0]              unique_total;
		logic [CORNERS-1:0]              flag_mask;
		logic                            table_full;
	} qvic_result_t;

endpackage
`default_nettype wire

// ===== sv/quad_vertex_index_compactor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quad_vertex_index_compactor_core: vertex ID deduplication for quads
//
// Each input beat carries one quad: four global vertex IDs and a flag that
// starts a new group and empties the table of unique IDs. Each input beat
// yields exactly one output beat: the local index of every corner, the IDs
// appended by this quad, the unique count and the per-corner flags.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. in_stall is high while a quad is being worked on.
// A corner that carries the reserved ID is settled by the reserved-ID check
// alone. Any other corner is checked, then the stored entries are read and
// compared in turn until one matches; on a miss of a table of N entries the
// scan is followed by one empty read, then the append or the drop. The result
// then moves into the output register, and the next quad is accepted in the
// cycle after the sequencer hands its predecessor to that register.
// The search speed is set by the single read port of the ID table and the
// one shared comparator, which look at one stored entry at a time.
// The finished result sits in an output register, so the next quad can be
// accepted while the receiver still stalls the previous result; the
// sequencer holds a second finished result until that register frees up.
// Reset empties the table (unique count zero) and sets reserved_id to
// 0xFFFF; the stored IDs themselves are not cleared, nor need they be.
// reserved_id is written through the APB port at byte address 0.
// ---------------------------------------------------------------------------
module quad_vertex_index_compactor_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [qvic_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [qvic_pkg::PDATA_W-1:0]    pwdata,
	output logic [qvic_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	// Input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            start_group,
	input  wire logic [qvic_pkg::ID_W-1:0]       vertex_a,
	input  wire logic [qvic_pkg::ID_W-1:0]       vertex_b,
	input  wire logic [qvic_pkg::ID_W-1:0]       vertex_c,
	input  wire logic [qvic_pkg::ID_W-1:0]       vertex_d,
	// Output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [qvic_pkg::LOCAL_W-1:0]         local_a,
	output logic [qvic_pkg::LOCAL_W-1:0]         local_b,
	output logic [qvic_pkg::LOCAL_W-1:0]         local_c,
	output logic [qvic_pkg::LOCAL_W-1:0]         local_d,
	output logic [qvic_pkg::ADDED_W-1:0]         added_count,
	output logic [qvic_pkg::ID_W-1:0]            added_first,
	output logic [qvic_pkg::ID_W-1:0]            added_second,
	output logic [qvic_pkg::ID_W-1:0]            added_third,
	output logic [qvic_pkg::ID_W-1:0]            added_fourth,
	output logic [qvic_pkg::TOTAL_W-1:0]         unique_total,
	output logic [qvic_pkg::CORNERS-1:0]         flag_mask,
	output logic                                 table_full
);

	localparam logic [qvic_pkg::PADDR_W-3:0] RESERVED_WORD =
		(qvic_pkg::PADDR_W-2)'(qvic_pkg::REG_RESERVED_ID);

	logic [qvic_pkg::ID_W-1:0]  reserved_id_q;
	logic                       cfg_write;
	logic                       reserved_sel;

	logic                       seq_idle;
	logic                       seq_start;
	logic                       res_valid;
	logic                       res_take;
	qvic_pkg::qvic_result_t     seq_result;
	qvic_pkg::qvic_ram_req_t    ram_req;
	logic [qvic_pkg::ID_W-1:0]  ram_rdata;
	qvic_pkg::qvic_ids_t        vertices;

	logic                       out_valid_q;
	qvic_pkg::qvic_result_t     out_q;

	// Configuration registers. Only word addresses are decoded; the low
	// two address bits select bytes within the word and are ignored.
	assign pready       = 1'b1;
	assign reserved_sel = (paddr[qvic_pkg::PADDR_W-1:2] == RESERVED_WORD);
	assign cfg_write    = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_id_q <= qvic_pkg::RESERVED_ID_RESET;
		end else if (cfg_write && reserved_sel) begin
			reserved_id_q <= pwdata[qvic_pkg::ID_W-1:0];
		end
	end

	assign prdata = reserved_sel ? qvic_pkg::PDATA_W'(reserved_id_q) : '0;

	// Input side: a quad is taken whenever the sequencer is idle.
	assign in_stall  = !seq_idle;
	assign seq_start = in_valid && seq_idle;
	assign vertices  = {vertex_d, vertex_c, vertex_b, vertex_a};

	qvic_search_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (seq_start),
		.start_group (start_group),
		.vertices    (vertices),
		.reserved_id (reserved_id_q),
		.idle        (seq_idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.result      (seq_result),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	qvic_id_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register: loads a finished result when it is empty or when
	// its current beat is leaving in this cycle.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= seq_result;
		end
	end

	assign out_valid    = out_valid_q;
	assign local_a      = out_q.locals[0];
	assign local_b      = out_q.locals[1];
	assign local_c      = out_q.locals[2];
	assign local_d      = out_q.locals[3];
	assign added_count  = out_q.added_count;
	assign added_first  = out_q.added[0];
	assign added_second = out_q.added[1];
	assign added_third  = out_q.added[2];
	assign added_fourth = out_q.added[3];
	assign unique_total = out_q.unique_total;
	assign flag_mask    = out_q.flag_mask;
	assign table_full   = out_q.table_full;

endmodule
`default_nettype wire

// ===== sv/qvic_id_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qvic_id_ram: table of unique vertex IDs
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module qvic_id_ram (
	input  wire logic                   clk,
	input  wire qvic_pkg::qvic_ram_req_t req,
	output logic [qvic_pkg::ID_W-1:0]   rdata
);

	logic [qvic_pkg::ID_W-1:0] mem [qvic_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/qvic_search_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qvic_search_seq: corner-by-corner search and append sequencer
// Walks the four corners in order, scans the ID table one entry per read
// with a single shared comparator, and appends IDs that are not found while there is room.
// ---------------------------------------------------------------------------
module qvic_search_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          start_group,
	input  wire qvic_pkg::qvic_ids_t           vertices,
	input  wire logic [qvic_pkg::ID_W-1:0]     reserved_id,
	output logic                               idle,
	output logic                               res_valid,
	input  wire logic                          res_take,
	output qvic_pkg::qvic_result_t             result,
	output qvic_pkg::qvic_ram_req_t            ram_req,
	input  wire logic [qvic_pkg::ID_W-1:0]     ram_rdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_APPEND = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	localparam logic [qvic_pkg::CNT_W-1:0] DEPTH_C =
		qvic_pkg::CNT_W'(qvic_pkg::TABLE_DEPTH);

	logic [2:0]                               state_q;
	logic [1:0]                               corner_q;
	logic [qvic_pkg::CNT_W-1:0]               count_q;
	logic [qvic_pkg::CNT_W-1:0]               idx_q;
	qvic_pkg::qvic_ids_t                      vert_q;
	logic [qvic_pkg::CORNERS-1:0][qvic_pkg::LOCAL_W-1:0] locals_q;
	qvic_pkg::qvic_ids_t                      added_q;
	logic [qvic_pkg::ADDED_W-1:0]             n_added_q;
	logic [qvic_pkg::CORNERS-1:0]             flags_q;
	logic                                     full_q;

	logic [qvic_pkg::ID_W-1:0] cur_id;
	logic [qvic_pkg::ID_W-1:0] cmp_b;
	logic                      cmp_eq;
	logic                      last_corner;

	assign cur_id      = vert_q[corner_q];
	assign last_corner = (corner_q == 2'd3);

	// The one comparator serves both the reserved-ID test and the table scan.
	assign cmp_b  = (state_q == S_CHECK) ? reserved_id : ram_rdata;
	assign cmp_eq = (cur_id == cmp_b);

	always_comb begin
		ram_req.we    = (state_q == S_APPEND) && (count_q != DEPTH_C);
		ram_req.waddr = count_q[qvic_pkg::IDX_W-1:0];
		ram_req.wdata = cur_id;
		ram_req.re    = (state_q == S_READ) && (idx_q != count_q);
		ram_req.raddr = idx_q[qvic_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= 2'd0;
			count_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						corner_q <= 2'd0;
						if (start_group) begin
							count_q <= '0;
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cmp_eq) begin
						corner_q <= corner_q + 2'd1;
						state_q  <= last_corner ? S_DONE : S_CHECK;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= (idx_q == count_q) ? S_APPEND : S_CMP;
				end
				S_CMP: begin
					if (cmp_eq) begin
						corner_q <= corner_q + 2'd1;
						state_q  <= last_corner ? S_DONE : S_CHECK;
					end else begin
						state_q <= S_READ;
					end
				end
				S_APPEND: begin
					if (count_q != DEPTH_C) begin
						count_q <= count_q + qvic_pkg::CNT_W'(1);
					end
					corner_q <= corner_q + 2'd1;
					state_q  <= last_corner ? S_DONE : S_CHECK;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item working registers; cleared when an item starts.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					vert_q    <= vertices;
					locals_q  <= '0;
					added_q   <= '0;
					n_added_q <= '0;
					flags_q   <= '0;
					full_q    <= 1'b0;
				end
			end
			S_CHECK: begin
				idx_q <= '0;
				if (cmp_eq) begin
					flags_q[corner_q] <= 1'b1;
				end
			end
			S_CMP: begin
				if (cmp_eq) begin
					locals_q[corner_q] <= qvic_pkg::LOCAL_W'(idx_q);
				end else begin
					idx_q <= idx_q + qvic_pkg::CNT_W'(1);
				end
			end
			S_APPEND: begin
				if (count_q == DEPTH_C) begin
					flags_q[corner_q] <= 1'b1;
					full_q            <= 1'b1;
				end else begin
					locals_q[corner_q]      <= qvic_pkg::LOCAL_W'(count_q);
					added_q[n_added_q[1:0]] <= cur_id;
					n_added_q               <= n_added_q + qvic_pkg::ADDED_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		result.locals       = locals_q;
		result.added_count  = n_added_q;
		result.added        = added_q;
		result.unique_total = qvic_pkg::TOTAL_W'(count_q);
		result.flag_mask    = flags_q;
		result.table_full   = full_q;
	end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the quad vertex index compactor
// Sends quads through the input channel while both channels idle and stall
// at random, rebuilds the table of unique vertex IDs beside the block and
// compares every result beat, field by field, with the expected one.
// ---------------------------------------------------------------------------
module testbench;

	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned DRAIN_CYCLES = 4200;
	localparam int unsigned CYCLE_LIMIT  = 6_000_000;
	localparam int unsigned N_STEPS      = 12;

	localparam logic [qvic_pkg::PADDR_W-1:0] RESERVED_ADDR =
		qvic_pkg::PADDR_W'(qvic_pkg::REG_RESERVED_ID * 4);
	// The next word up maps to no register, so a write there must change nothing.
	localparam logic [qvic_pkg::PADDR_W-1:0] UNMAPPED_ADDR =
		qvic_pkg::PADDR_W'((qvic_pkg::REG_RESERVED_ID + 1) * 4);

	// One row of the directed part. Rows with typed set carry a result that
	// is plain from the inputs alone; all others go through the predictor.
	typedef struct {
		logic [qvic_pkg::ID_W-1:0] reserved;
		logic                      start;
		qvic_pkg::qvic_ids_t       ids;
		bit                        typed;
		qvic_pkg::qvic_result_t    known;
	} quad_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [qvic_pkg::PADDR_W-1:0]        paddr;
	logic [qvic_pkg::PDATA_W-1:0]        pwdata;
	logic [qvic_pkg::PDATA_W-1:0]        prdata;
	logic                                pready;
	logic                                in_valid;
	logic                                in_stall;
	logic                                start_group;
	logic [qvic_pkg::ID_W-1:0]           vertex_a;
	logic [qvic_pkg::ID_W-1:0]           vertex_b;
	logic [qvic_pkg::ID_W-1:0]           vertex_c;
	logic [qvic_pkg::ID_W-1:0]           vertex_d;
	logic                                out_valid;
	logic                                out_stall;
	logic [qvic_pkg::LOCAL_W-1:0]        local_a;
	logic [qvic_pkg::LOCAL_W-1:0]        local_b;
	logic [qvic_pkg::LOCAL_W-1:0]        local_c;
	logic [qvic_pkg::LOCAL_W-1:0]        local_d;
	logic [qvic_pkg::ADDED_W-1:0]        added_count;
	logic [qvic_pkg::ID_W-1:0]           added_first;
	logic [qvic_pkg::ID_W-1:0]           added_second;
	logic [qvic_pkg::ID_W-1:0]           added_third;
	logic [qvic_pkg::ID_W-1:0]           added_fourth;
	logic [qvic_pkg::TOTAL_W-1:0]        unique_total;
	logic [qvic_pkg::CORNERS-1:0]        flag_mask;
	logic                                table_full;

	// Shadow of the block: the unique IDs of the current group in first-seen
	// order, how many of them there are, and the reserved ID register.
	logic [qvic_pkg::ID_W-1:0]           seen_ids [qvic_pkg::TABLE_DEPTH];
	int unsigned                         seen_count = 0;
	logic [qvic_pkg::ID_W-1:0]           cfg_reserved = qvic_pkg::RESERVED_ID_RESET;

	// Expected result beats, oldest first, one per accepted quad.
	qvic_pkg::qvic_result_t              awaited_results [$];

	// IDs handed out so far in the group being generated; used to build
	// quads that hit entries already in the table.
	logic [qvic_pkg::ID_W-1:0]           group_ids [$];

	// The directed row on the input port, when its result is typed in.
	bit                                  row_typed = 1'b0;
	qvic_pkg::qvic_result_t              row_known = '0;

	bit                                  no_idle = 1'b0;
	bit                                  backlog_req = 1'b0;
	bit                                  backlog_done = 1'b0;
	int unsigned                         failures = 0;
	int unsigned                         cycle_count = 0;

	quad_vertex_index_compactor_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_group  (start_group),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.vertex_c     (vertex_c),
		.vertex_d     (vertex_d),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.local_a      (local_a),
		.local_b      (local_b),
		.local_c      (local_c),
		.local_d      (local_d),
		.added_count  (added_count),
		.added_first  (added_first),
		.added_second (added_second),
		.added_third  (added_third),
		.added_fourth (added_fourth),
		.unique_total (unique_total),
		.flag_mask    (flag_mask),
		.table_full   (table_full)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Predictor. The start flag empties the table, then the corners are
	// resolved in order a, b, c, d. A reserved ID is flagged and neither
	// searched nor stored. A known ID returns its index. A new ID is appended
	// while there is room; once the table is full it is dropped and flagged,
	// and table_full goes high. A repeat inside one quad resolves to the
	// index its first occurrence got. Unused added slots stay zero.
	function automatic qvic_pkg::qvic_result_t compact_quad(logic start,
			qvic_pkg::qvic_ids_t ids);
		qvic_pkg::qvic_result_t r;
		int unsigned            n_added;
		int unsigned            pos;
		bit                     hit;
		r = '0;
		n_added = 0;
		if (start)
			seen_count = 0;
		for (int k = 0; k < qvic_pkg::CORNERS; k++) begin
			hit = 1'b0;
			pos = 0;
			if (ids[k] == cfg_reserved) begin
				r.flag_mask[k] = 1'b1;
			end else begin
				for (int unsigned i = 0; i < seen_count; i++)
					if (!hit && seen_ids[i] == ids[k]) begin
						hit = 1'b1;
						pos = i;
					end
				if (hit) begin
					r.locals[k] = qvic_pkg::LOCAL_W'(pos);
				end else if (seen_count < qvic_pkg::TABLE_DEPTH) begin
					seen_ids[seen_count] = ids[k];
					r.locals[k] = qvic_pkg::LOCAL_W'(seen_count);
					seen_count++;
					r.added[n_added] = ids[k];
					n_added++;
				end else begin
					r.flag_mask[k] = 1'b1;
					r.table_full = 1'b1;
				end
			end
		end
		r.added_count = qvic_pkg::ADDED_W'(n_added);
		r.unique_total = qvic_pkg::TOTAL_W'(seen_count);
		return r;
	endfunction

	function automatic quad_row_t quad_row(logic [qvic_pkg::ID_W-1:0] rsv, logic start,
			logic [qvic_pkg::ID_W-1:0] a, logic [qvic_pkg::ID_W-1:0] b,
			logic [qvic_pkg::ID_W-1:0] c, logic [qvic_pkg::ID_W-1:0] d);
		quad_row_t r;
		r.reserved = rsv;
		r.start = start;
		r.ids = {d, c, b, a};
		r.typed = 1'b0;
		r.known = '0;
		return r;
	endfunction

	function automatic quad_row_t quad_known(logic [qvic_pkg::ID_W-1:0] rsv, logic start,
			logic [qvic_pkg::ID_W-1:0] a, logic [qvic_pkg::ID_W-1:0] b,
			logic [qvic_pkg::ID_W-1:0] c, logic [qvic_pkg::ID_W-1:0] d,
			logic [qvic_pkg::LOCAL_W-1:0] l0, logic [qvic_pkg::LOCAL_W-1:0] l1,
			logic [qvic_pkg::LOCAL_W-1:0] l2, logic [qvic_pkg::LOCAL_W-1:0] l3,
			logic [qvic_pkg::ADDED_W-1:0] cnt,
			logic [qvic_pkg::ID_W-1:0] n0, logic [qvic_pkg::ID_W-1:0] n1,
			logic [qvic_pkg::ID_W-1:0] n2, logic [qvic_pkg::ID_W-1:0] n3,
			logic [qvic_pkg::TOTAL_W-1:0] total, logic [qvic_pkg::CORNERS-1:0] flags,
			logic full);
		quad_row_t r;
		r = quad_row(rsv, start, a, b, c, d);
		r.typed = 1'b1;
		r.known.locals = {l3, l2, l1, l0};
		r.known.added_count = cnt;
		r.known.added = {n3, n2, n1, n0};
		r.known.unique_total = total;
		r.known.flag_mask = flags;
		r.known.table_full = full;
		return r;
	endfunction

	// Draws one corner ID: now and then the reserved value, often an ID the
	// group already used, otherwise a fresh one from a narrow pool or from
	// the whole 16-bit range.
	function automatic logic [qvic_pkg::ID_W-1:0] pick_vertex(int unsigned reuse_pct,
			bit narrow);
		int unsigned               roll;
		logic [qvic_pkg::ID_W-1:0] id;
		roll = $urandom_range(99);
		if (roll < 8) begin
			id = cfg_reserved;
		end else if (roll < 8 + reuse_pct && group_ids.size() > 0) begin
			id = group_ids[$urandom_range(group_ids.size() - 1)];
		end else begin
			id = narrow ? qvic_pkg::ID_W'($urandom_range(47)) : qvic_pkg::ID_W'($urandom);
			group_ids.push_back(id);
		end
		return id;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endtask

	// Offers one quad beat, entered and left at a falling edge. Random idle
	// cycles come first; the payload then holds until the beat is taken.
	task automatic send_quad(logic start, qvic_pkg::qvic_ids_t ids, bit typed,
			qvic_pkg::qvic_result_t known);
		while (!no_idle && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		start_group <= start;
		vertex_a <= ids[0];
		vertex_b <= ids[1];
		vertex_c <= ids[2];
		vertex_d <= ids[3];
		row_typed = typed;
		row_known = known;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Lets the block run dry so that the register may be rewritten.
	task automatic drain_quads();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// One write, then one read of the same address. Only the reserved ID
	// register has a value to read back.
	task automatic apb_write(logic [qvic_pkg::PADDR_W-1:0] addr,
			logic [qvic_pkg::PDATA_W-1:0] value);
		logic [qvic_pkg::PDATA_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == RESERVED_ADDR) begin
			cfg_reserved = value[qvic_pkg::ID_W-1:0];
			check_field("prdata",
				{{(qvic_pkg::PDATA_W - qvic_pkg::ID_W){1'b0}}, cfg_reserved}, readback);
		end
	endtask

	// Short groups, mostly opened by the start flag. One group in ten leaves
	// the flag low and so carries on with the table of the group before.
	task automatic run_groups(int unsigned n_items);
		int unsigned         sent;
		int unsigned         len;
		bit                  narrow;
		logic                start;
		qvic_pkg::qvic_ids_t ids;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 6);
			narrow = $urandom_range(1);
			group_ids.delete();
			for (int unsigned q = 0; q < len && sent < n_items; q++) begin
				for (int k = 0; k < qvic_pkg::CORNERS; k++)
					ids[k] = pick_vertex(30, narrow);
				start = (q == 0) ? ($urandom_range(9) != 0) : 1'b0;
				send_quad(start, ids, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Receiver. It stalls the output at random, not at all while no_idle is
	// set, and once holds off for a long stretch so that the output register
	// and the sequencer fill up and the block has to stall its input.
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (backlog_req && !backlog_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				backlog_done = 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 35);
			end
		end
	end

	// Both channels are watched at the rising edge. A quad taken on this edge
	// is predicted first; a result beat taken on the same edge can only
	// belong to an earlier quad, so the order inside the block is harmless.
	always @(posedge clk) begin : beat_monitor
		qvic_pkg::qvic_result_t want;
		if (in_valid === 1'b1 && in_stall === 1'b0) begin
			want = compact_quad(start_group, {vertex_d, vertex_c, vertex_b, vertex_a});
			if (row_typed)
				want = row_known;
			awaited_results.push_back(want);
		end
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				$error("result beat arrived with no quad outstanding");
				failures++;
			end else begin
				want = awaited_results.pop_front();
				check_field("local_a", want.locals[0], local_a);
				check_field("local_b", want.locals[1], local_b);
				check_field("local_c", want.locals[2], local_c);
				check_field("local_d", want.locals[3], local_d);
				check_field("added_count", want.added_count, added_count);
				check_field("added_first", want.added[0], added_first);
				check_field("added_second", want.added[1], added_second);
				check_field("added_third", want.added[2], added_third);
				check_field("added_fourth", want.added[3], added_fourth);
				check_field("unique_total", want.unique_total, unique_total);
				check_field("flag_mask", want.flag_mask, flag_mask);
				check_field("table_full", want.table_full, table_full);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : stimulus
		quad_row_t           steps [N_STEPS];
		qvic_pkg::qvic_ids_t ids;
		int unsigned         over;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		start_group = 1'b0;
		vertex_a = '0;
		vertex_b = '0;
		vertex_c = '0;
		vertex_d = '0;
		arst_n = 1'b0;

		// Directed rows. The first ones run with the reserved ID still at its
		// reset value, which is how that value gets checked; the column also
		// moves the register to the other extreme, zero, where 0xFFFF turns
		// into an ordinary ID. Covered: a fresh group of four new IDs, a quad
		// made only of known IDs, reserved corners, one ID on all corners,
		// an all-reserved quad, repeats inside a quad, and the bit patterns
		// that drive every vertex bit both ways.
		steps = '{
			quad_known(16'hFFFF, 1'b1, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
				0, 1, 2, 3, 4, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 4, 4'b0000, 1'b0),
			quad_known(16'hFFFF, 1'b0, 16'h0003, 16'h0002, 16'h0001, 16'h0000,
				3, 2, 1, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4, 4'b0000, 1'b0),
			quad_known(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0005, 16'h0005,
				0, 0, 4, 4, 1, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 5, 4'b0011, 1'b0),
			quad_known(16'hFFFF, 1'b1, 16'h0007, 16'h0007, 16'h0007, 16'h0007,
				0, 0, 0, 0, 1, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 1, 4'b0000, 1'b0),
			quad_known(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 4'b1111, 1'b0),
			quad_row(16'hFFFF, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hFFFE),
			quad_row(16'hFFFF, 1'b1, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h0001),
			quad_row(16'hFFFF, 1'b0, 16'h0001, 16'h8000, 16'h1234, 16'hFFFF),
			quad_row(16'hFFFF, 1'b0, 16'h1111, 16'h1111, 16'h2222, 16'h1111),
			quad_known(16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
				0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 4'b1111, 1'b0),
			quad_known(16'h0000, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001,
				0, 0, 0, 1, 2, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 2, 4'b0010, 1'b0),
			quad_row(16'h0000, 1'b0, 16'h0F0F, 16'hF0F0, 16'h0001, 16'h0000)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int unsigned i = 0; i < N_STEPS; i++) begin
			if (steps[i].reserved !== cfg_reserved) begin
				drain_quads();
				apb_write(RESERVED_ADDR, qvic_pkg::PDATA_W'(steps[i].reserved));
			end
			send_quad(steps[i].start, steps[i].ids, steps[i].typed, steps[i].known);
		end

		// Short groups under an arbitrary reserved ID, with the long output
		// hold-off starting right away while quads keep coming.
		drain_quads();
		apb_write(RESERVED_ADDR, qvic_pkg::PDATA_W'($urandom_range(1, 65534)));
		backlog_req = 1'b1;
		run_groups(50);

		// One long group with mostly fresh IDs that fills the table to the
		// last entry and then keeps going, so that new IDs get dropped while
		// known ones still resolve. The predictor has counted each quad by the
		// time the loop checks whether the table is full.
		drain_quads();
		apb_write(RESERVED_ADDR, qvic_pkg::PDATA_W'(qvic_pkg::RESERVED_ID_RESET));
		group_ids.delete();
		over = 0;
		for (int unsigned q = 0; q < 260 && over < 10; q++) begin
			for (int k = 0; k < qvic_pkg::CORNERS; k++)
				ids[k] = pick_vertex(15, 1'b0);
			send_quad(q == 0, ids, 1'b0, '0);
			if (seen_count == qvic_pkg::TABLE_DEPTH)
				over++;
		end

		// A write to an address with no register behind it, then a reserved
		// ID inside the narrow pool so that it comes up on its own. The first
		// half of this phase runs with no idling on either side.
		drain_quads();
		apb_write(UNMAPPED_ADDR, qvic_pkg::PDATA_W'($urandom));
		apb_write(RESERVED_ADDR, qvic_pkg::PDATA_W'($urandom_range(47)));
		no_idle = 1'b1;
		run_groups(30);
		no_idle = 1'b0;
		run_groups(30);

		// Wait out every expected beat, then a full worst-case quad time in
		// case a stray beat is still on its way.
		drain_quads();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/qvic_pkg.sv
sv/qvic_id_ram.sv
sv/qvic_search_seq.sv
sv/quad_vertex_index_compactor_core.sv
tb/sv/testbench.sv
